// File: rtl/ifd_pkg.sv
// Shared types, codes and helper functions for the IPv4 forwarding decision block.
package ifd_pkg;

   // Default sizes handed to the top level parameters.
   localparam int DEF_ROUTE_ENTRIES = 16;
   localparam int DEF_NUM_PORTS     = 4;

   // Fixed field widths.
   localparam int PORT_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int ADDR_W      = 32;
   localparam int SUM_W       = 20;

   // Header constants.
   localparam logic [3:0] IHL_NO_OPTIONS = 4'd5;
   localparam logic [7:0] PROTO_ICMP     = 8'd1;
   localparam logic [7:0] PROTO_TCP      = 8'd6;
   localparam logic [7:0] PROTO_UDP      = 8'd17;

   // ICMP type and code values.
   localparam logic [7:0] ICMP_TYPE_ECHO_REPLY    = 8'd0;
   localparam logic [7:0] ICMP_TYPE_UNREACH       = 8'd3;
   localparam logic [7:0] ICMP_TYPE_ECHO_REQUEST  = 8'd8;
   localparam logic [7:0] ICMP_TYPE_TIME_EXCEEDED = 8'd11;
   localparam logic [7:0] ICMP_CODE_PORT_UNREACH  = 8'd3;

   typedef enum logic [1:0] {
      OP_HEADER           = 2'd0,
      OP_ROUTE_WRITE      = 2'd1,
      OP_ROUTE_INVALIDATE = 2'd2,
      OP_RESERVED         = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ACT_DROP    = 3'd0,
      ACT_FWD     = 3'd1,
      ACT_ECHO    = 3'd2,
      ACT_PORTUN  = 3'd3,
      ACT_TIMEX   = 3'd4,
      ACT_NETUN   = 3'd5,
      ACT_IGNORE  = 3'd6,
      ACT_ACK     = 3'd7
   } action_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [31:0]       header_word0;
      logic [31:0]       header_word1;
      logic [31:0]       header_word2;
      logic [31:0]       src_addr;
      logic [31:0]       dst_addr;
      logic [7:0]        icmp_kind;
      logic [PORT_W-1:0] in_port;
      logic [3:0]        route_index;
      logic [31:0]       route_gateway;
      logic [PORT_W-1:0] route_port;
   } req_type;

   typedef struct packed {
      action_type        action;
      logic [PORT_W-1:0] out_port;
      logic [31:0]       next_hop;
      logic [7:0]        new_ttl;
      logic [15:0]       new_checksum;
      logic [7:0]        icmp_type_out;
      logic [7:0]        icmp_code_out;
      logic [31:0]       reply_src_addr;
   } rsp_type;

   // Route table update command.
   typedef struct packed {
      logic              write;
      logic              invalidate;
      logic [3:0]        index;
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] gateway;
      logic [PORT_W-1:0] port;
   } route_wr_type;

   // One candidate route in the ranking tree.
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] gateway;
      logic [PORT_W-1:0] port;
   } cand_type;

   // The right candidate wins only with a strictly longer mask, so ties go to the lower index.
   function automatic cand_type pick_route(cand_type lo, cand_type hi);
      cand_type win;
      if (hi.valid && (!lo.valid || (hi.mask > lo.mask))) begin
         win = hi;
      end else begin
         win = lo;
      end
      return win;
   endfunction

   // Folds a raw halfword sum into the ones' complement checksum.
   function automatic logic [15:0] ones_fold(logic [SUM_W-1:0] raw);
      logic [16:0] t;
      t = 17'(raw[SUM_W-1:16]) + 17'(raw[15:0]);
      t = 17'(t[16]) + 17'(t[15:0]);
      return ~t[15:0];
   endfunction

endpackage

// File: rtl/ifd_lpm.sv
// Route table with a pipelined longest-prefix ranking tree.
module ifd_lpm #(
   parameter int ROUTE_ENTRIES = ifd_pkg::DEF_ROUTE_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ifd_pkg::route_wr_type       route_wr,
   input  logic [ifd_pkg::ADDR_W-1:0]  lookup_addr,
   output ifd_pkg::cand_type           best_route
);

   localparam int LEVELS = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int PAD    = 2 ** LEVELS;
   localparam int EXT_W  = 9;

   logic [ifd_pkg::ADDR_W-1:0] prefix_ff  [ROUTE_ENTRIES];
   logic [ifd_pkg::ADDR_W-1:0] mask_ff    [ROUTE_ENTRIES];
   logic [ifd_pkg::ADDR_W-1:0] gateway_ff [ROUTE_ENTRIES];
   logic [ifd_pkg::PORT_W-1:0] port_ff    [ROUTE_ENTRIES];
   logic                       valid_ff   [ROUTE_ENTRIES];

   ifd_pkg::cand_type leaf [PAD];
   ifd_pkg::cand_type node_in [1:PAD-1];
   ifd_pkg::cand_type node_ff [1:PAD-1];

   logic [EXT_W-1:0] wr_index_ext;

   assign wr_index_ext = EXT_W'(route_wr.index);

   // Table update; an index beyond the table matches no entry and is dropped.
   always_ff @(posedge clock) begin
      for (int k = 0; k < ROUTE_ENTRIES; k++) begin
         if (route_wr.write && (wr_index_ext == EXT_W'(k))) begin
            prefix_ff[k]  <= route_wr.prefix;
            mask_ff[k]    <= route_wr.mask;
            gateway_ff[k] <= route_wr.gateway;
            port_ff[k]    <= route_wr.port;
         end
      end
   end

   // Valid bits clear on reset so that the payload stores need no clearing.
   always_ff @(posedge clock) begin
      for (int k = 0; k < ROUTE_ENTRIES; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (wr_index_ext == EXT_W'(k)) begin
            if (route_wr.write) begin
               valid_ff[k] <= 1'b1;
            end else if (route_wr.invalidate) begin
               valid_ff[k] <= 1'b0;
            end
         end
      end
   end

   // Each entry presents itself as a candidate when it is valid and its prefix matches.
   for (genvar e = 0; e < PAD; e++) begin : g_leaf
      if (e < ROUTE_ENTRIES) begin : g_real
         assign leaf[e].valid   = valid_ff[e] &&
            ((lookup_addr & mask_ff[e]) == (prefix_ff[e] & mask_ff[e]));
         assign leaf[e].mask    = mask_ff[e];
         assign leaf[e].gateway = gateway_ff[e];
         assign leaf[e].port    = port_ff[e];
      end else begin : g_pad
         assign leaf[e] = '0;
      end
   end

   // Heap-ordered tree: each level is one register stage, node i has children 2i and 2i+1.
   for (genvar i = 1; i < PAD; i++) begin : g_node
      if (i >= PAD / 2) begin : g_bottom
         assign node_in[i] = ifd_pkg::pick_route(leaf[2*i-PAD], leaf[2*i+1-PAD]);
      end else begin : g_inner
         assign node_in[i] = ifd_pkg::pick_route(node_ff[2*i], node_ff[2*i+1]);
      end

      always_ff @(posedge clock) begin
         node_ff[i] <= node_in[i];
      end
   end

   assign best_route = node_ff[1];

endmodule

// File: rtl/ipv4_forwarding_decision.sv
// Top level of the IPv4 forwarding decision: header checks, local delivery and route lookup.
// One item is accepted in every cycle; busy stays low.
// The result strobe is registered: an item passes the input stage, then the ranking tree
// over the route table with one register stage per level, then the output register.
// The receiver cannot stall.
// Synchronous reset clears the interface addresses, all route valid bits and pipeline valids.
module ipv4_forwarding_decision #(
   parameter int ROUTE_ENTRIES = ifd_pkg::DEF_ROUTE_ENTRIES,
   parameter int NUM_PORTS     = ifd_pkg::DEF_NUM_PORTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  ifd_pkg::req_type                req_data,
   output logic                            rsp_strobe,
   output ifd_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [ifd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wdata
);

   localparam int LEVELS = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

   // Per-item facts carried alongside the ranking tree.
   typedef struct packed {
      logic [1:0]                 opcode;
      logic                       ihl_ok;
      logic [15:0]                rx_sum;
      logic [7:0]                 ttl;
      logic [7:0]                 proto;
      logic                       echo_req;
      logic                       local_dst;
      logic [ifd_pkg::PORT_W-1:0] port;
      logic [ifd_pkg::ADDR_W-1:0] port_addr;
      logic [ifd_pkg::ADDR_W-1:0] dst;
      logic [ifd_pkg::SUM_W-1:0]  raw_sum;
      logic [ifd_pkg::SUM_W-1:0]  raw_sum_dec;
   } side_type;

   logic [ifd_pkg::ADDR_W-1:0] if_addr_ff [NUM_PORTS];

   logic             accept;
   logic             s1_valid_ff;
   ifd_pkg::req_type s1_item_ff;

   ifd_pkg::route_wr_type route_wr;
   ifd_pkg::cand_type     best_route;

   side_type side_in;
   side_type side_ff       [LEVELS];
   logic     side_valid_ff [LEVELS];

   ifd_pkg::rsp_type rsp_in;
   ifd_pkg::rsp_type rsp_ff;
   logic             rsp_strobe_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Interface address registers; indexes at or beyond the port count are not stored.
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_PORTS; k++) begin
         if (reset) begin
            if_addr_ff[k] <= '0;
         end else if (csr_we && (csr_index == ifd_pkg::CSR_INDEX_W'(k))) begin
            if_addr_ff[k] <= csr_wdata;
         end
      end
   end

   // Route table commands take effect at the transfer, ahead of any later lookup.
   always_comb begin
      route_wr.write      = accept && (req_data.opcode == ifd_pkg::OP_ROUTE_WRITE);
      route_wr.invalidate = accept && (req_data.opcode == ifd_pkg::OP_ROUTE_INVALIDATE);
      route_wr.index      = req_data.route_index;
      route_wr.prefix     = req_data.dst_addr;
      route_wr.mask       = req_data.src_addr;
      route_wr.gateway    = req_data.route_gateway;
      route_wr.port       = req_data.route_port;
   end

   // Input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= req_data;
   end

   ifd_lpm #(
      .ROUTE_ENTRIES(ROUTE_ENTRIES)
   ) u_lpm (
      .clock      (clock),
      .reset      (reset),
      .route_wr   (route_wr),
      .lookup_addr(s1_item_ff.dst_addr),
      .best_route (best_route)
   );

   // Raw header sum, interface address compare and field decode.
   always_comb begin
      logic [ifd_pkg::SUM_W-1:0] sum;
      sum = ifd_pkg::SUM_W'(s1_item_ff.header_word0[31:16])
          + ifd_pkg::SUM_W'(s1_item_ff.header_word0[15:0])
          + ifd_pkg::SUM_W'(s1_item_ff.header_word1[31:16])
          + ifd_pkg::SUM_W'(s1_item_ff.header_word1[15:0])
          + ifd_pkg::SUM_W'(s1_item_ff.header_word2[31:16])
          + ifd_pkg::SUM_W'(s1_item_ff.src_addr[31:16])
          + ifd_pkg::SUM_W'(s1_item_ff.src_addr[15:0])
          + ifd_pkg::SUM_W'(s1_item_ff.dst_addr[31:16])
          + ifd_pkg::SUM_W'(s1_item_ff.dst_addr[15:0]);

      side_in.opcode    = s1_item_ff.opcode;
      side_in.ihl_ok    = (s1_item_ff.header_word0[27:24] == ifd_pkg::IHL_NO_OPTIONS);
      side_in.rx_sum    = s1_item_ff.header_word2[15:0];
      side_in.ttl       = s1_item_ff.header_word2[31:24];
      side_in.proto     = s1_item_ff.header_word2[23:16];
      side_in.echo_req  = (s1_item_ff.icmp_kind == ifd_pkg::ICMP_TYPE_ECHO_REQUEST);
      side_in.port      = s1_item_ff.in_port;
      side_in.dst       = s1_item_ff.dst_addr;
      side_in.raw_sum   = sum;
      // Lowering TTL by one takes 256 off the raw sum; only used when TTL is at least two.
      side_in.raw_sum_dec = sum - ifd_pkg::SUM_W'(256);
      side_in.local_dst = 1'b0;
      side_in.port_addr = '0;
      for (int k = 0; k < NUM_PORTS; k++) begin
         if (s1_item_ff.in_port == ifd_pkg::PORT_W'(k)) begin
            side_in.port_addr = if_addr_ff[k];
         end
         if (if_addr_ff[k] == s1_item_ff.dst_addr) begin
            side_in.local_dst = 1'b1;
         end
      end
   end

   // Delay line that keeps the header facts aligned with the ranking tree.
   always_ff @(posedge clock) begin
      for (int l = 0; l < LEVELS; l++) begin
         if (reset) begin
            side_valid_ff[l] <= 1'b0;
         end else if (l == 0) begin
            side_valid_ff[l] <= s1_valid_ff;
         end else begin
            side_valid_ff[l] <= side_valid_ff[l-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int l = 1; l < LEVELS; l++) begin
         side_ff[l] <= side_ff[l-1];
      end
   end

   // Final decision.
   always_comb begin
      side_type s;
      s      = side_ff[LEVELS-1];
      rsp_in = '0;
      case (s.opcode)
         ifd_pkg::OP_HEADER: begin
            if ((ifd_pkg::ones_fold(s.raw_sum) != s.rx_sum) || !s.ihl_ok) begin
               rsp_in.action = ifd_pkg::ACT_DROP;
            end else if (s.ttl <= 8'd1) begin
               rsp_in.action         = ifd_pkg::ACT_TIMEX;
               rsp_in.out_port       = s.port;
               rsp_in.icmp_type_out  = ifd_pkg::ICMP_TYPE_TIME_EXCEEDED;
               rsp_in.reply_src_addr = s.port_addr;
            end else begin
               rsp_in.out_port     = s.port;
               rsp_in.new_ttl      = s.ttl - 8'd1;
               rsp_in.new_checksum = ifd_pkg::ones_fold(s.raw_sum_dec);
               if (s.local_dst) begin
                  if ((s.proto == ifd_pkg::PROTO_TCP) || (s.proto == ifd_pkg::PROTO_UDP)) begin
                     rsp_in.action         = ifd_pkg::ACT_PORTUN;
                     rsp_in.icmp_type_out  = ifd_pkg::ICMP_TYPE_UNREACH;
                     rsp_in.icmp_code_out  = ifd_pkg::ICMP_CODE_PORT_UNREACH;
                     rsp_in.reply_src_addr = s.port_addr;
                  end else if ((s.proto == ifd_pkg::PROTO_ICMP) && s.echo_req) begin
                     rsp_in.action         = ifd_pkg::ACT_ECHO;
                     rsp_in.icmp_type_out  = ifd_pkg::ICMP_TYPE_ECHO_REPLY;
                     rsp_in.reply_src_addr = s.dst;
                  end else begin
                     rsp_in.action = ifd_pkg::ACT_IGNORE;
                  end
               end else if (best_route.valid) begin
                  rsp_in.action   = ifd_pkg::ACT_FWD;
                  rsp_in.out_port = best_route.port;
                  rsp_in.next_hop = best_route.gateway;
               end else begin
                  rsp_in.action         = ifd_pkg::ACT_NETUN;
                  rsp_in.icmp_type_out  = ifd_pkg::ICMP_TYPE_UNREACH;
                  rsp_in.reply_src_addr = s.port_addr;
               end
            end
         end
         ifd_pkg::OP_ROUTE_WRITE, ifd_pkg::OP_ROUTE_INVALIDATE: begin
            rsp_in.action = ifd_pkg::ACT_ACK;
         end
         default: begin
            rsp_in.action = ifd_pkg::ACT_IGNORE;
         end
      endcase
   end

   // Output register; each result is shown for exactly one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= side_valid_ff[LEVELS-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
